// ===== src/nsc_pkg.sv =====
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_STRICT_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH  = 1'b1;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;
    localparam logic [7:0] COUNT_MAX        = 8'd255;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_BODY   = 3'd1,
        PH_HEX_HI = 3'd2,
        PH_HEX_LO = 3'd3,
        PH_CR     = 3'd4,
        PH_LF     = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } nsc_in_t;

    typedef struct packed {
        logic       sentence_ok;
        logic [7:0] xor_sum;
        logic [7:0] byte_count;
    } nsc_out_t;

    // Result request from the parser to the result register
    typedef struct packed {
        logic     valid;
        nsc_out_t data;
    } nsc_res_req_t;

endpackage

// ===== src/nsc_parser.sv =====
module nsc_parser import nsc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  nsc_in_t      in_item,
    input  logic         strict_mode,
    input  logic [7:0]   max_length,
    input  logic         res_slot_free,
    output nsc_res_req_t res_req
);

    logic       in_valid_reg;
    nsc_in_t    in_item_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] nibble_reg, nibble_next;
    logic [7:0] count_reg, count_next;
    logic       good_reg, good_next;

    logic       advance;
    logic [4:0] hex;

    // Bit 4 flags a byte that is not a hex digit; value then reads as zero
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            v = {1'b0, b[3:0] + 4'd9};
        return v;
    endfunction

    // A final byte waits for room in the result register; others move straight on
    assign advance  = in_valid_reg && (!in_item_reg.final_byte || res_slot_free);
    assign in_ready = !in_valid_reg || advance;
    assign hex      = hex_value(in_item_reg.char_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            in_item_reg <= in_item;
        end
    end

    // Next sentence state
    always_comb begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        good_next   = good_reg;
        if (phase_reg != PH_DONE) begin
            if (count_reg == COUNT_MAX) good_next = 1'b0;
            else count_next = count_reg + 8'd1;
        end
        unique case (phase_reg)
            PH_START: begin
                if (in_item_reg.char_byte != CH_DOLLAR) good_next = 1'b0;
                phase_next = PH_BODY;
            end
            PH_BODY: begin
                if (in_item_reg.char_byte == CH_STAR) begin
                    phase_next = PH_HEX_HI;
                end else if (in_item_reg.char_byte == CH_CR) begin
                    if (strict_mode) good_next = 1'b0;
                    phase_next = PH_LF;
                end else begin
                    xor_next = xor_reg ^ in_item_reg.char_byte;
                end
            end
            PH_HEX_HI: begin
                if (hex[4]) good_next = 1'b0;
                nibble_next = hex[3:0];
                phase_next  = PH_HEX_LO;
            end
            PH_HEX_LO: begin
                if (hex[4] || {nibble_reg, hex[3:0]} != xor_reg) good_next = 1'b0;
                phase_next = PH_CR;
            end
            PH_CR: begin
                if (in_item_reg.char_byte == CH_CR) begin
                    phase_next = PH_LF;
                end else begin
                    good_next  = 1'b0;
                    phase_next = PH_DONE;
                end
            end
            PH_LF: begin
                if (in_item_reg.char_byte != CH_LF) good_next = 1'b0;
                phase_next = PH_DONE;
            end
            default: begin
                // after LF, or after a missing CR: drop the byte
            end
        endcase
    end

    // Result request on the final byte
    always_comb begin
        res_req.valid            = advance && in_item_reg.final_byte;
        res_req.data.sentence_ok = good_next && (phase_next == PH_DONE)
                                   && (count_next <= max_length);
        res_req.data.xor_sum     = xor_next;
        res_req.data.byte_count  = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            xor_reg    <= '0;
            nibble_reg <= '0;
            count_reg  <= '0;
            good_reg   <= 1'b1;
        end else if (advance) begin
            if (in_item_reg.final_byte) begin
                phase_reg  <= PH_START;
                xor_reg    <= '0;
                nibble_reg <= '0;
                count_reg  <= '0;
                good_reg   <= 1'b1;
            end else begin
                phase_reg  <= phase_next;
                xor_reg    <= xor_next;
                nibble_reg <= nibble_next;
                count_reg  <= count_next;
                good_reg   <= good_next;
            end
        end
    end

endmodule

// ===== src/nsc_result_reg.sv =====
module nsc_result_reg import nsc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  nsc_res_req_t res_req,
    output logic         res_slot_free,
    output logic         m_valid,
    input  logic         m_ready,
    output nsc_out_t     m_result
);

    logic     out_valid_reg;
    nsc_out_t out_data_reg;

    assign res_slot_free = !out_valid_reg || m_ready;
    assign m_valid       = out_valid_reg;
    assign m_result      = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_slot_free) begin
            out_valid_reg <= res_req.valid;
        end
        // parser only raises a request when the slot is free
        if (res_req.valid) begin
            out_data_reg <= res_req.data;
        end
    end

endmodule

// ===== src/nmea_sentence_checker.sv =====
// NMEA 0183 sentence checker. Feed one sentence as a run of bytes on s_item, one byte per
// request, with final_byte set on its last byte; that byte yields one result on m_result
// (pass flag, XOR of the bytes between '$' and '*' or CR, and the length counted through
// LF, saturating at 255). Every other byte yields nothing. The block takes one byte per
// clock: a byte passes an input register, the sentence state is updated in the following
// cycle, and a result sits in an output register until taken, so a new byte can enter while
// a result waits. Only a final byte stalls, and only while the output register is still full.
// m_valid is driven by the output register that holds the result. Write strict_mode (index 0)
// and max_length (index 1, reset 82) through cfg_we/cfg_index/cfg_wdata between sentences.
module nmea_sentence_checker import nsc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  nsc_in_t                s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output nsc_out_t               m_result
);

    logic         strict_mode_reg;
    logic [7:0]   max_length_reg;
    logic         res_slot_free;
    nsc_res_req_t res_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_mode_reg <= 1'b0;
            max_length_reg  <= MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STRICT_MODE: strict_mode_reg <= cfg_wdata[0];
                REG_MAX_LENGTH:  max_length_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    nsc_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_item       (s_item),
        .strict_mode   (strict_mode_reg),
        .max_length    (max_length_reg),
        .res_slot_free (res_slot_free),
        .res_req       (res_req)
    );

    nsc_result_reg u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_req       (res_req),
        .res_slot_free (res_slot_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result)
    );

endmodule
